/* src/gkdg_pkg.sv */
// ----------------------------------------------------------------------------
// gkdg_pkg
// Shared types, codes and constants of the kernel density gradient unit.
// ----------------------------------------------------------------------------
package gkdg_pkg;

	// default sizes
	localparam int MAX_SAMPLES_DEF     = 1024;
	localparam int MAX_DIMS_DEF        = 8;
	localparam int EXP_TABLE_DEPTH_DEF = 256;

	// widest index fields carried through the command queue
	localparam int ADDR_FIELD_W = 16;
	localparam int DIM_FIELD_W  = 4;

	// command queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// register indexes
	localparam logic [2:0] REG_SAMPLES_USED = 3'd0;
	localparam logic [2:0] REG_DIMS_USED    = 3'd1;
	localparam logic [2:0] REG_KERNEL_COEFF = 3'd2;
	localparam logic [2:0] REG_SAMPLE_SCALE = 3'd3;
	localparam logic [2:0] REG_INV_SHAT_SQ  = 3'd4;

	// command codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_QCOORD = 2'd1;
	localparam logic [1:0] OP_QLAST  = 2'd2;

	// fixed-point constants
	localparam logic [63:0] LN2_Q30   = 64'd744261118;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	// input item
	typedef struct packed {
		logic               kind;
		logic [9:0]         point_index;
		logic [2:0]         dim_index;
		logic signed [31:0] coord_value;
	} item_t;

	// result item
	typedef struct packed {
		logic [2:0]         out_dim;
		logic signed [31:0] grad_value;
		logic               zero_weight;
		logic               last;
	} result_t;

	// classified command from front to back
	typedef struct packed {
		logic [1:0]              op;
		logic [ADDR_FIELD_W-1:0] addr;
		logic [DIM_FIELD_W-1:0]  dim;
		logic [31:0]             data;
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	// 16-term series for exp(x), x in Q2.30
	function automatic logic [63:0] exp_series(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] sum;
		term = 64'd1 << 30;
		sum  = term;
		for (int n = 1; n <= 15; n++) begin
			term = ((term * x) >> 30) / 64'(n);
			sum  = sum + term;
		end
		return sum;
	endfunction

endpackage

/* src/gaussian_kernel_density_gradient_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_kernel_density_gradient_unit
// Gaussian kernel density gradient (mean-shift score) in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we, cfg_index, cfg_wdata write one register a cycle;
//   the user must write only while the unit is idle; the block does not
//   enforce it. Input: an item transfers when start is high and busy is low.
//   Loads write one scaled sample coordinate, query items one query coordinate;
//   coordinate dims_used-1 starts a walk over samples 0..samples_used-1.
//   Items pass through a four-entry command queue; busy is high only while
//   that queue is full, so items keep transferring during a walk until it fills.
//   Walk: one sample per cycle from the row-wide store, through an
//   eight-stage weight pipeline.
//   Results: one per coordinate, each on result for one cycle with
//   result_valid high; each waits for the divider and the two multiply
//   steps (one a cycle when all weights underflow). The receiver cannot
//   stall: every result is taken.
//   Reset: registers return to their defaults, query point and sums clear,
//   the sample store holds nothing valid until loaded.
// ----------------------------------------------------------------------------
module gaussian_kernel_density_gradient_unit #(
	parameter int MAX_SAMPLES     = gkdg_pkg::MAX_SAMPLES_DEF,
	parameter int MAX_DIMS        = gkdg_pkg::MAX_DIMS_DEF,
	parameter int EXP_TABLE_DEPTH = gkdg_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gkdg_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	output logic              result_valid,
	output gkdg_pkg::result_t result
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int ND_W  = $clog2(MAX_DIMS + 1);

	logic [10:0] samples_used_q;
	logic [3:0]  dims_used_q;
	logic [31:0] kernel_coeff_q;
	logic [15:0] sample_scale_q;
	logic [31:0] inv_shat_sq_q;

	logic [CNT_W-1:0]  ns;
	logic [ND_W-1:0]   nd;
	gkdg_pkg::qhead_t  head;
	logic              pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_used_q <= 11'd1024;
			dims_used_q    <= 4'd8;
			kernel_coeff_q <= 32'd65536;
			sample_scale_q <= 16'd65535;
			inv_shat_sq_q  <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				gkdg_pkg::REG_SAMPLES_USED: samples_used_q <= cfg_wdata[10:0];
				gkdg_pkg::REG_DIMS_USED:    dims_used_q    <= cfg_wdata[3:0];
				gkdg_pkg::REG_KERNEL_COEFF: kernel_coeff_q <= cfg_wdata;
				gkdg_pkg::REG_SAMPLE_SCALE: sample_scale_q <= cfg_wdata[15:0];
				gkdg_pkg::REG_INV_SHAT_SQ:  inv_shat_sq_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// counts clamped into range
	always_comb begin
		if (samples_used_q == '0) begin
			ns = CNT_W'(1);
		end else if (32'(samples_used_q) > 32'(MAX_SAMPLES)) begin
			ns = CNT_W'(MAX_SAMPLES);
		end else begin
			ns = CNT_W'(samples_used_q);
		end
		if (dims_used_q == '0) begin
			nd = ND_W'(1);
		end else if (32'(dims_used_q) > 32'(MAX_DIMS)) begin
			nd = ND_W'(MAX_DIMS);
		end else begin
			nd = ND_W'(dims_used_q);
		end
	end

	gkdg_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_DIMS    (MAX_DIMS),
		.ND_W        (ND_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.sample_scale (sample_scale_q),
		.nd           (nd),
		.head         (head),
		.pop          (pop)
	);

	gkdg_engine #(
		.MAX_SAMPLES     (MAX_SAMPLES),
		.MAX_DIMS        (MAX_DIMS),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
		.CNT_W           (CNT_W),
		.ND_W            (ND_W)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.ns           (ns),
		.nd           (nd),
		.kernel_coeff (kernel_coeff_q),
		.inv_shat_sq  (inv_shat_sq_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* src/gkdg_front.sv */
// ----------------------------------------------------------------------------
// gkdg_front
// Accepts items, classifies them, scales sample loads and queues commands.
// ----------------------------------------------------------------------------
module gkdg_front #(
	parameter int MAX_SAMPLES = gkdg_pkg::MAX_SAMPLES_DEF,
	parameter int MAX_DIMS    = gkdg_pkg::MAX_DIMS_DEF,
	parameter int ND_W        = $clog2(MAX_DIMS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  gkdg_pkg::item_t       item,
	input  logic [15:0]           sample_scale,
	input  logic [ND_W-1:0]       nd,
	output gkdg_pkg::qhead_t      head,
	input  logic                  pop
);

	gkdg_pkg::cmd_t              queue_q [gkdg_pkg::QUEUE_DEPTH];
	logic [gkdg_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [gkdg_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [gkdg_pkg::QPTR_W:0]   count_q;

	logic                  accept;
	logic                  keep;
	gkdg_pkg::cmd_t        cmd;
	logic signed [48:0]    scaled;
	logic signed [48:0]    rounded;

	assign busy   = (count_q == (gkdg_pkg::QPTR_W + 1)'(gkdg_pkg::QUEUE_DEPTH));
	assign accept = start && !busy;

	// scale a sample coordinate with rounding
	assign scaled  = 49'(item.coord_value) * 49'(signed'({1'b0, sample_scale}));
	assign rounded = scaled + 49'sd32768;

	// classify the item
	always_comb begin
		cmd.addr = gkdg_pkg::ADDR_FIELD_W'(item.point_index);
		cmd.dim  = gkdg_pkg::DIM_FIELD_W'(item.dim_index);
		cmd.data = item.coord_value;
		cmd.op   = gkdg_pkg::OP_QCOORD;
		keep     = 1'b0;
		if (!item.kind) begin
			cmd.op   = gkdg_pkg::OP_LOAD;
			cmd.data = rounded[47:16];
			keep     = (32'(item.point_index) < 32'(MAX_SAMPLES)) &&
			           (32'(item.dim_index) < 32'(MAX_DIMS));
		end else begin
			keep = 32'(item.dim_index) < 32'(MAX_DIMS);
			if (32'(item.dim_index) == 32'(nd) - 32'd1) begin
				cmd.op = gkdg_pkg::OP_QLAST;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept && keep) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (gkdg_pkg::QPTR_W + 1)'(accept && keep)
			                   - (gkdg_pkg::QPTR_W + 1)'(pop);
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

endmodule

/* src/gkdg_divider.sv */
// ----------------------------------------------------------------------------
// gkdg_divider
// Restoring divider, 64-bit dividend by 48-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module gkdg_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [47:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [47:0] rem_q;
	logic [63:0] quo_q;
	logic [47:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;

	logic [48:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[63]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? 48'(rem_sh - {1'b0, dvs_q}) : rem_sh[47:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/gkdg_engine.sv */
// ----------------------------------------------------------------------------
// gkdg_engine
// Back end: sample store, query point, weight pipeline and result sequencer.
// ----------------------------------------------------------------------------
module gkdg_engine #(
	parameter int MAX_SAMPLES     = gkdg_pkg::MAX_SAMPLES_DEF,
	parameter int MAX_DIMS        = gkdg_pkg::MAX_DIMS_DEF,
	parameter int EXP_TABLE_DEPTH = gkdg_pkg::EXP_TABLE_DEPTH_DEF,
	parameter int CNT_W           = $clog2(MAX_SAMPLES + 1),
	parameter int ND_W            = $clog2(MAX_DIMS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gkdg_pkg::qhead_t      head,
	output logic                  pop,
	input  logic [CNT_W-1:0]      ns,
	input  logic [ND_W-1:0]       nd,
	input  logic [31:0]           kernel_coeff,
	input  logic [31:0]           inv_shat_sq,
	output logic                  result_valid,
	output gkdg_pkg::result_t     result
);

	localparam int SAMP_W = $clog2(MAX_SAMPLES);
	localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);

	// sequencer codes
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_WALK     = 3'd1;
	localparam logic [2:0] ST_DRAIN    = 3'd2;
	localparam logic [2:0] ST_DIV_GO   = 3'd3;
	localparam logic [2:0] ST_DIV_WAIT = 3'd4;
	localparam logic [2:0] ST_MUL_LO   = 3'd5;
	localparam logic [2:0] ST_MUL_HI   = 3'd6;
	localparam logic [2:0] ST_EMIT     = 3'd7;

	// sample store, one row per sample
	logic [MAX_DIMS-1:0][31:0] store [MAX_SAMPLES];

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   smp_q;
	logic [DIM_W-1:0]   oi_q;
	logic [7:0]         v_q;
	logic signed [31:0] query_q [MAX_DIMS];
	logic [47:0]        wsum_q;
	logic [63:0]        dsum_q  [MAX_DIMS];
	logic [63:0]        quo_q;
	logic [63:0]        plo_q;
	logic [63:0]        phi_q;
	logic               result_valid_q;
	gkdg_pkg::result_t  result_q;

	// pipeline registers
	logic [MAX_DIMS-1:0][31:0] row_s1;
	logic signed [32:0] diff_s2 [MAX_DIMS];
	logic signed [32:0] diff_s3 [MAX_DIMS];
	logic signed [32:0] diff_s4 [MAX_DIMS];
	logic signed [32:0] diff_s5 [MAX_DIMS];
	logic signed [32:0] diff_s6 [MAX_DIMS];
	logic signed [32:0] diff_s7 [MAX_DIMS];
	logic [49:0]        sq_s3   [MAX_DIMS];
	logic [52:0]        d2_s4;
	logic [47:0]        a_s5;
	logic               zero_s5;
	logic [24:0]        y_s6;
	logic               zero_s6;
	logic [16:0]        w_s7;
	logic [16:0]        w_s8;
	logic signed [50:0] wd_s8   [MAX_DIMS];

	logic [16:0]        exp_tab [EXP_TABLE_DEPTH];

	logic               issue;
	logic               div_go;
	logic               div_done;
	logic [63:0]        div_quo;
	logic [63:0]        dsel;
	logic               dneg;
	logic [63:0]        dmag;
	logic               last_dim;

	logic [52:0]        d2_sum;
	logic [63:0]        kc_prod;
	logic [40:0]        y_prod;
	logic [31:0]        idx_prod;
	logic [IDX_W-1:0]   idx;
	logic [8:0]         n_exp;
	logic [16:0]        w_raw;
	logic [95:0]        m_sum;
	logic [79:0]        m_full;
	logic [31:0]        lim;
	logic [31:0]        m_sat;

	// exponential table, 2^(-k/depth) in Q1.16
	for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
		localparam logic [63:0] X = (64'(k) * gkdg_pkg::LN2_Q30) / 64'(EXP_TABLE_DEPTH);
		localparam logic [63:0] S = gkdg_pkg::exp_series(X);
		localparam logic [63:0] V = ((64'd1 << 46) + (S >> 1)) / S;
		assign exp_tab[k] = V[16:0];
	end

	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign issue    = (state_q == ST_WALK);
	assign div_go   = (state_q == ST_DIV_GO) && (wsum_q != '0);
	assign last_dim = (32'(oi_q) == 32'(nd) - 32'd1);

	// store write and row read
	always_ff @(posedge clk) begin
		if (pop && head.cmd.op == gkdg_pkg::OP_LOAD) begin
			store[head.cmd.addr[SAMP_W-1:0]][head.cmd.dim[DIM_W-1:0]] <= head.cmd.data;
		end
		if (issue) begin
			row_s1 <= store[smp_q[SAMP_W-1:0]];
		end
	end

	// distance, square and sum
	always_comb begin
		d2_sum = '0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			d2_sum = d2_sum + 53'(sq_s3[i]);
		end
	end

	// exponent argument and base-2 split
	assign kc_prod  = 64'(kernel_coeff) * 64'(d2_s4[31:0]);
	assign y_prod   = 41'(a_s5[23:0]) * 41'(gkdg_pkg::LOG2E_Q16);
	assign n_exp    = y_s6[24:16];
	assign idx_prod = 32'(y_s6[15:0]) * 32'(EXP_TABLE_DEPTH);
	assign idx      = idx_prod[16 +: IDX_W];
	assign w_raw    = (n_exp >= 9'd32) ? 17'd0 : (exp_tab[idx] >> n_exp[4:0]);

	// weight pipeline
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (32'(i) < 32'(nd)) begin
				diff_s2[i] <= 33'(signed'(row_s1[i])) - 33'(query_q[i]);
			end else begin
				diff_s2[i] <= '0;
			end
			sq_s3[i]   <= 50'(((66'(diff_s2[i] < 0 ? -diff_s2[i] : diff_s2[i])) *
			                    (66'(diff_s2[i] < 0 ? -diff_s2[i] : diff_s2[i]))) >> 16);
			diff_s3[i] <= diff_s2[i];
			diff_s4[i] <= diff_s3[i];
			diff_s5[i] <= diff_s4[i];
			diff_s6[i] <= diff_s5[i];
			diff_s7[i] <= diff_s6[i];
			wd_s8[i]   <= 51'(diff_s7[i]) * 51'(signed'({1'b0, w_s7}));
		end
		d2_s4   <= d2_sum;
		a_s5    <= kc_prod[63:16];
		zero_s5 <= (kernel_coeff != '0) && (d2_s4[52:32] != '0);
		y_s6    <= y_prod[40:16];
		zero_s6 <= zero_s5 || (a_s5[47:24] != '0);
		w_s7    <= zero_s6 ? 17'd0 : w_raw;
		w_s8    <= w_s7;
	end

	// selected difference sum and its magnitude
	assign dsel = dsum_q[oi_q];
	assign dneg = dsel[63];
	assign dmag = dneg ? (64'd0 - dsel) : dsel;

	gkdg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dmag),
		.divisor  (wsum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// scale by 1/shat^2 and saturate
	assign m_sum  = {phi_q, 32'd0} + {32'd0, plo_q};
	assign m_full = m_sum[95:16];
	assign lim    = dneg ? 32'h8000_0000 : 32'h7fff_ffff;
	assign m_sat  = (m_full > 80'(lim)) ? lim : m_full[31:0];

	// sequencer, query point and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			smp_q          <= '0;
			oi_q           <= '0;
			v_q            <= '0;
			wsum_q         <= '0;
			quo_q          <= '0;
			plo_q          <= '0;
			phi_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				query_q[i] <= '0;
				dsum_q[i]  <= '0;
			end
		end else begin
			v_q            <= {v_q[6:0], issue};
			result_valid_q <= 1'b0;
			// accumulate a finished sample
			if (v_q[7]) begin
				wsum_q <= wsum_q + 48'(w_s8);
				for (int i = 0; i < MAX_DIMS; i++) begin
					dsum_q[i] <= dsum_q[i] + 64'(wd_s8[i]);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid && head.cmd.op != gkdg_pkg::OP_LOAD) begin
						query_q[head.cmd.dim[DIM_W-1:0]] <= signed'(head.cmd.data);
						if (head.cmd.op == gkdg_pkg::OP_QLAST) begin
							state_q <= ST_WALK;
							smp_q   <= '0;
							wsum_q  <= '0;
							for (int i = 0; i < MAX_DIMS; i++) begin
								dsum_q[i] <= '0;
							end
						end
					end
				end
				ST_WALK: begin
					smp_q <= smp_q + 1'b1;
					if (smp_q == ns - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_q == '0) begin
						state_q <= ST_DIV_GO;
						oi_q    <= '0;
					end
				end
				ST_DIV_GO: begin
					if (wsum_q == '0) begin
						result_valid_q       <= 1'b1;
						result_q.out_dim     <= 3'(oi_q);
						result_q.grad_value  <= '0;
						result_q.zero_weight <= 1'b1;
						result_q.last        <= last_dim;
						oi_q                 <= oi_q + 1'b1;
						if (last_dim) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: begin
					plo_q   <= 64'(quo_q[31:0]) * 64'(inv_shat_sq);
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					phi_q   <= 64'(quo_q[63:32]) * 64'(inv_shat_sq);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					result_valid_q       <= 1'b1;
					result_q.out_dim     <= 3'(oi_q);
					result_q.grad_value  <= dneg ? signed'(32'd0 - m_sat) : signed'(m_sat);
					result_q.zero_weight <= 1'b0;
					result_q.last        <= last_dim;
					oi_q                 <= oi_q + 1'b1;
					state_q              <= last_dim ? ST_IDLE : ST_DIV_GO;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* src/gkdg_checker.sv */
// ----------------------------------------------------------------------------
// gkdg_checker
// Port-level checks on the result stream of the gradient unit.
// ----------------------------------------------------------------------------
module gkdg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input gkdg_pkg::result_t result
);

	// a forced-zero result carries a zero value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_weight |-> result.grad_value == 32'sd0)
		else $error("zero-weight result with non-zero value");

	// a query's final result is followed by a gap: the next needs a walk
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result straight after the last of a query");

	// a divided result needs the divider before the next one
	a_gap_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.zero_weight |=> !result_valid)
		else $error("back-to-back results on the divide path");

	// dimensions step up by one within a query
	a_dim_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) && !$past(result.last) |->
		result.out_dim == $past(result.out_dim) + 3'd1)
		else $error("result dimensions out of order");

endmodule

bind gaussian_kernel_density_gradient_unit gkdg_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result       (result)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the kernel density gradient unit. Sample loads and
// query coordinates are driven from a queue with random idle bursts, the
// expected gradient components are predicted on every transfer and each result
// strobe is checked field by field against the oldest expected component.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_SAMP   = 1024;
	localparam int N_DIM    = 8;
	localparam int TAB_SIZE = 256;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1700;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	gkdg_pkg::item_t   item = '0;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = gkdg_pkg::REG_SAMPLES_USED;
	logic [31:0]       cfg_wdata = '0;
	logic              result_valid;
	gkdg_pkg::result_t result;

	gaussian_kernel_density_gradient_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.result_valid(result_valid),
		.result      (result)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] exp_tab [TAB_SIZE];
	logic signed [31:0] samp_mem [N_SAMP*N_DIM];
	logic signed [31:0] query_pt [N_DIM];
	logic [10:0] r_samples;
	logic [3:0]  r_dims;
	logic [31:0] r_kcoeff;
	logic [15:0] r_scale;
	logic [31:0] r_inv;

	gkdg_pkg::item_t   pending_items[$];
	gkdg_pkg::result_t expected_grads[$];
	int      mismatches = 0;
	bit      idle_on = 1'b1;
	bit      item_taken = 1'b0;
	int      idle_left = 0;
	int      stall_cnt = 0;

	// power-of-two table, Q1.16
	function automatic void build_exp_tab();
		logic [63:0] x, term, sum;
		for (int k = 0; k < TAB_SIZE; k++) begin
			x = (64'(k) * gkdg_pkg::LN2_Q30) / TAB_SIZE;
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 15; n++) begin
				term = ((term * x) >> 30) / 64'(n);
				sum = sum + term;
			end
			exp_tab[k] = 32'(((64'd1 << 46) + (sum >> 1)) / sum);
		end
	endfunction

	function automatic logic [63:0] gauss_weight(logic [63:0] d2);
		logic [63:0] a, y, n, idx;
		if (r_kcoeff == 0)
			a = 0;
		else if (d2[63:32] != 0)
			return 0;
		else
			a = (64'(r_kcoeff) * d2) >> 16;
		if (a >= (64'd1 << 24))
			return 0;
		y = (a * 64'(gkdg_pkg::LOG2E_Q16)) >> 16;
		n = y >> 16;
		if (n >= 32)
			return 0;
		idx = ((y & 64'hFFFF) * TAB_SIZE) >> 16;
		return 64'(exp_tab[idx] >> n);
	endfunction

	function automatic logic [31:0] scale_grad(logic [63:0] ds, logic [63:0] w);
		logic        neg;
		logic [63:0] mag, r, m, lim;
		logic [127:0] prod;
		neg = ds[63];
		mag = neg ? -ds : ds;
		r = mag / w;
		lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
		prod = 128'(r) * 128'(r_inv);
		if (prod[127:64] != 0)
			m = lim;
		else
			m = prod[79:16];
		if (m > lim)
			m = lim;
		return neg ? 32'(-m) : 32'(m);
	endfunction

	// apply one transfer, push expected gradient components
	function automatic void density_step(gkdg_pkg::item_t it);
		int ns, nd;
		logic [63:0] d2, w, wsum, ad;
		logic [63:0] dsum [N_DIM];
		longint d, p;
		gkdg_pkg::result_t r;
		if (!it.kind) begin
			p = longint'(it.coord_value) * longint'({1'b0, r_scale}) + 32768;
			samp_mem[it.point_index*N_DIM + it.dim_index] = 32'(p >>> 16);
			return;
		end
		query_pt[it.dim_index] = it.coord_value;
		nd = (r_dims == 0) ? 1 : (r_dims > N_DIM) ? N_DIM : r_dims;
		if (it.dim_index != nd - 1)
			return;
		ns = (r_samples == 0) ? 1 : (r_samples > N_SAMP) ? N_SAMP : r_samples;
		wsum = 0;
		for (int i = 0; i < N_DIM; i++)
			dsum[i] = 0;
		for (int j = 0; j < ns; j++) begin
			d2 = 0;
			for (int i = 0; i < nd; i++) begin
				d = longint'(samp_mem[j*N_DIM + i]) - longint'(query_pt[i]);
				ad = (d < 0) ? 64'(-d) : 64'(d);
				d2 = d2 + ((ad * ad) >> 16);
			end
			w = gauss_weight(d2);
			wsum = wsum + w;
			for (int i = 0; i < nd; i++) begin
				d = longint'(samp_mem[j*N_DIM + i]) - longint'(query_pt[i]);
				dsum[i] = dsum[i] + 64'(d) * w;
			end
		end
		wsum = wsum & 64'hFFFF_FFFF_FFFF;
		for (int i = 0; i < nd; i++) begin
			r.out_dim = 3'(i);
			r.zero_weight = (wsum == 0);
			r.grad_value = (wsum == 0) ? '0 : scale_grad(dsum[i], wsum);
			r.last = (i == nd - 1);
			expected_grads.push_back(r);
		end
	endfunction

	// result check and transfer prediction
	always @(posedge clk) begin
		gkdg_pkg::result_t e;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_grads.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result dim=%0d grad=%0d zw=%0b last=%0b",
							result.out_dim, result.grad_value, result.zero_weight, result.last);
				end else begin
					e = expected_grads.pop_front();
					if (result !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
								e.out_dim, e.grad_value, e.zero_weight, e.last,
								result.out_dim, result.grad_value, result.zero_weight, result.last);
					end
				end
			end
			if (start && !busy)
				density_step(item);
			item_taken <= start && !busy;
			// watchdog on cycles without any transfer
			if ((start && !busy) || result_valid || cfg_we)
				stall_cnt <= 0;
			else if (stall_cnt >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else
				stall_cnt <= stall_cnt + 1;
		end
	end

	// item driver with random idle bursts
	always @(negedge clk) begin
		logic nxt_start;
		nxt_start = start;
		if (arst_n && !(start && !item_taken)) begin
			if (idle_left > 0) begin
				idle_left--;
				nxt_start = 1'b0;
			end else if (pending_items.size() != 0) begin
				item <= pending_items.pop_front();
				nxt_start = 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					idle_left = $urandom_range(1, 19);
			end else
				nxt_start = 1'b0;
		end
		start <= nxt_start;
	end

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			gkdg_pkg::REG_SAMPLES_USED: r_samples = val[10:0];
			gkdg_pkg::REG_DIMS_USED:    r_dims = val[3:0];
			gkdg_pkg::REG_KERNEL_COEFF: r_kcoeff = val;
			gkdg_pkg::REG_SAMPLE_SCALE: r_scale = val[15:0];
			gkdg_pkg::REG_INV_SHAT_SQ:  r_inv = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic push_item(logic k, logic [9:0] pi, logic [2:0] di, logic [31:0] v);
		gkdg_pkg::item_t it;
		it.kind = k;
		it.point_index = pi;
		it.dim_index = di;
		it.coord_value = v;
		pending_items.push_back(it);
	endtask

	// wait until all transfers and results are through, then let the walk settle
	task automatic drain();
		while (pending_items.size() != 0 || start || expected_grads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
		endcase
	endfunction

	function automatic logic [31:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return 1 << 12;
			3: return 1 << 20;
			4: return $urandom;
			default: return 1 << 16;
		endcase
	endfunction

	function automatic logic [31:0] pick_inv();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return 1;
			3: return $urandom;
			default: return 1 << 16;
		endcase
	endfunction

	// one setting: registers, full sample load, then query sequences with noise
	task automatic run_phase(logic [10:0] ns_reg, logic [3:0] nd_reg, int n_query);
		int ns, nd, sent;
		logic [2:0] d0;
		cfg_write(gkdg_pkg::REG_SAMPLES_USED, 32'(ns_reg));
		cfg_write(gkdg_pkg::REG_DIMS_USED, 32'(nd_reg));
		cfg_write(gkdg_pkg::REG_KERNEL_COEFF, pick_coeff());
		cfg_write(gkdg_pkg::REG_SAMPLE_SCALE,
			$urandom_range(0, 2) == 0 ? 32'hFFFF : 32'($urandom_range(0, 65535)));
		cfg_write(gkdg_pkg::REG_INV_SHAT_SQ, pick_inv());
		cfg_write(3'd7, $urandom);
		ns = (ns_reg == 0) ? 1 : (ns_reg > N_SAMP) ? N_SAMP : ns_reg;
		nd = (nd_reg == 0) ? 1 : (nd_reg > N_DIM) ? N_DIM : nd_reg;
		for (int j = 0; j < ns; j++)
			for (int i = 0; i < nd; i++)
				push_item(1'b0, 10'(j), 3'(i), rand_coord());
		sent = 0;
		while (sent < n_query) begin
			case ($urandom_range(0, 9))
				0: begin
					push_item(1'b0, 10'($urandom), 3'($urandom), rand_coord());
					sent++;
				end
				1: begin
					// stray coordinate, any number
					push_item(1'b1, 10'($urandom), 3'($urandom), rand_coord());
					sent++;
				end
				default: begin
					// well-formed query, sometimes only its tail
					d0 = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, nd - 1)) : 3'd0;
					for (int i = d0; i < nd; i++) begin
						push_item(1'b1, 10'($urandom), 3'(i), rand_coord());
						sent++;
					end
				end
			endcase
		end
		drain();
	endtask

	initial begin
		build_exp_tab();
		for (int i = 0; i < N_SAMP*N_DIM; i++)
			samp_mem[i] = '0;
		for (int i = 0; i < N_DIM; i++)
			query_pt[i] = '0;
		r_samples = 11'd1024;
		r_dims = 4'd8;
		r_kcoeff = 32'd65536;
		r_scale = 16'hFFFF;
		r_inv = 32'd65536;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (20) @(posedge clk);

		// directed: extreme samples, a near query, a far query giving zero weight
		cfg_write(gkdg_pkg::REG_SAMPLES_USED, 32'd2);
		cfg_write(gkdg_pkg::REG_DIMS_USED, 32'd8);
		cfg_write(gkdg_pkg::REG_KERNEL_COEFF, 32'd65536);
		cfg_write(gkdg_pkg::REG_SAMPLE_SCALE, 32'hFFFF);
		cfg_write(gkdg_pkg::REG_INV_SHAT_SQ, 32'd65536);
		push_item(1'b0, 10'd0, 3'd0, 32'h8000_0000);
		push_item(1'b0, 10'd0, 3'd1, 32'h7FFF_FFFF);
		for (int i = 2; i < N_DIM; i++)
			push_item(1'b0, 10'd0, 3'(i), 32'(i) << 16);
		for (int i = 0; i < N_DIM; i++)
			push_item(1'b0, 10'd1, 3'(i), 32'(i * 9000) - 32'd30000);
		push_item(1'b0, 10'd1023, 3'd7, 32'hFFFF_FFFF);
		for (int i = 0; i < N_DIM; i++)
			push_item(1'b1, 10'd1023, 3'(i), 32'(i * 9000) - 32'd29000);
		push_item(1'b1, 10'd0, 3'd7, 32'h7FFF_FFFF);
		drain();

		// random settings, zero counts, an over-range dims_used and extreme coefficients among them
		run_phase(11'd3, 4'd4, 12);
		run_phase(11'd0, 4'd0, 8);
		run_phase(11'd4, 4'd1, 6);
		run_phase(11'd2, 4'd15, 12);
		run_phase(11'($urandom_range(1, 4)), 4'($urandom_range(1, 4)), 10);
		run_phase(11'd1, 4'd8, 10);
		idle_on = 1'b0;
		run_phase(11'($urandom_range(1, 4)), 4'($urandom_range(1, 4)), 12);

		if (mismatches == 0 && expected_grads.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
src/gkdg_pkg.sv
src/gkdg_front.sv
src/gkdg_divider.sv
src/gkdg_engine.sv
src/gaussian_kernel_density_gradient_unit.sv
src/gkdg_checker.sv
sim/tb_top.sv
